// ===== rtl/core/wvt_pkg.sv =====
// Shared types, constants and tables for the water vapor transmittance pipeline.
`timescale 1ns / 1ps

package wvt_pkg;

  localparam int unsigned FIRST_BAND_DEF = 4;
  localparam int unsigned BAND_W         = 4;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 21;
  localparam int unsigned OFFSET_W       = 21;
  localparam int unsigned SLOPE_W        = 18;
  localparam int unsigned Z_W            = 41;

  localparam logic signed [17:0] LN2_Q16   = 18'sd45426;
  localparam logic signed [17:0] LOG2E_Q16 = 18'sd94548;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE0  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE1  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE2  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE3  = 3'd7;

  localparam logic signed [OFFSET_W-1:0] OFFSET0_RST = -21'sd565500;
  localparam logic signed [OFFSET_W-1:0] OFFSET1_RST = -21'sd455023;
  localparam logic signed [OFFSET_W-1:0] OFFSET2_RST = -21'sd380786;
  localparam logic signed [OFFSET_W-1:0] OFFSET3_RST = -21'sd361147;
  localparam logic [SLOPE_W-1:0] SLOPE0_RST = 18'd50211;
  localparam logic [SLOPE_W-1:0] SLOPE1_RST = 18'd53321;
  localparam logic [SLOPE_W-1:0] SLOPE2_RST = 18'd40485;
  localparam logic [SLOPE_W-1:0] SLOPE3_RST = 18'd44436;

  // Control that travels beside the data through every stage.
  typedef struct packed {
    logic       valid;
    logic       fitted;
    logic       zero;
    logic [1:0] idx;
  } wvt_tag_t;

  // 2^(2^-(k+1)) in Q30.
  function automatic logic [30:0] pow2_frac(input logic [3:0] k);
    logic [30:0] f;
    case (k)
      4'd0:    f = 31'd1518500250;
      4'd1:    f = 31'd1276901417;
      4'd2:    f = 31'd1170923762;
      4'd3:    f = 31'd1121280436;
      4'd4:    f = 31'd1097253708;
      4'd5:    f = 31'd1085434106;
      4'd6:    f = 31'd1079572136;
      4'd7:    f = 31'd1076653033;
      4'd8:    f = 31'd1075196444;
      4'd9:    f = 31'd1074468888;
      4'd10:   f = 31'd1074105294;
      4'd11:   f = 31'd1073923544;
      4'd12:   f = 31'd1073832680;
      4'd13:   f = 31'd1073787251;
      4'd14:   f = 31'd1073764537;
      default: f = 31'd1073753180;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/core/wvt_log2.sv =====
// Pipelined base-2 logarithm of a 32-bit product, one squaring per stage.
`timescale 1ns / 1ps

module wvt_log2 (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [31:0]         in_p,
  input  wvt_pkg::wvt_tag_t   in_tag,
  output logic signed [21:0]  out_l2,
  output wvt_pkg::wvt_tag_t   out_tag
);
  import wvt_pkg::*;

  localparam int unsigned NSTEP = 16;

  logic [30:0] m_r    [0:NSTEP];
  logic [15:0] frac_r [0:NSTEP];
  logic [4:0]  e_r    [0:NSTEP];
  wvt_tag_t    tag_r  [0:NSTEP];

  logic [4:0]  lead;
  logic [30:0] norm;

  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (in_p[i]) lead = 5'(i);
    end
    if (lead == 5'd31) norm = in_p[31:1];
    else norm = 31'(in_p << (5'd30 - lead));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]    <= norm;
      e_r[0]    <= lead;
      frac_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= NSTEP; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] hi;
    assign sq = m_r[k-1] * m_r[k-1];
    assign hi = sq[61:30];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k] <= '0;
      end else if (en) begin
        tag_r[k] <= tag_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        e_r[k] <= e_r[k-1];
        if (hi[31]) begin
          m_r[k]    <= hi[31:1];
          frac_r[k] <= {frac_r[k-1][14:0], 1'b1};
        end else begin
          m_r[k]    <= hi[30:0];
          frac_r[k] <= {frac_r[k-1][14:0], 1'b0};
        end
      end
    end
  end

  // The product is Q10.22, so 22 comes off the integer part.
  assign out_l2  = $signed({1'b0, e_r[NSTEP], frac_r[NSTEP]}) - 22'sd1441792;
  assign out_tag = tag_r[NSTEP];

  a_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (tag_r[0].valid && !tag_r[0].zero) |-> m_r[0][30])
    else $error("log2 mantissa not normalized");

endmodule

// ===== rtl/core/wvt_exp2.sv =====
// Pipelined base-2 exponential of a Q16 value, one table factor per stage.
`timescale 1ns / 1ps

module wvt_exp2 #(
  parameter int unsigned VW = 28
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic signed [VW-1:0]         in_v,
  input  wvt_pkg::wvt_tag_t            in_tag,
  output logic [wvt_pkg::Z_W-1:0]      out_z,
  output wvt_pkg::wvt_tag_t            out_tag
);
  import wvt_pkg::*;

  localparam int unsigned NSTEP = 16;
  localparam int unsigned IW    = VW - 16;
  localparam logic signed [IW-1:0] IP_CAP = IW'(24);
  localparam logic signed [IW-1:0] IP_ONE = IW'(14);
  localparam logic signed [IW-1:0] IP_LOW = IW'(-17);
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  logic signed [IW-1:0] ip_r  [0:NSTEP];
  logic [15:0]          fr_r  [0:NSTEP];
  logic [30:0]          m_r   [0:NSTEP];
  wvt_tag_t             tag_r [0:NSTEP];
  wvt_tag_t             out_tag_r;
  logic [Z_W-1:0]       z_r, z_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ip_r[0] <= in_v[VW-1:16];
      fr_r[0] <= in_v[15:0];
      m_r[0]  <= ONE_Q30;
    end
  end

  for (genvar k = 1; k <= NSTEP; k++) begin : g_mul
    logic [61:0] prod;
    assign prod = m_r[k-1] * pow2_frac(4'(k - 1));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[k] <= '0;
      end else if (en) begin
        tag_r[k] <= tag_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ip_r[k] <= ip_r[k-1];
        fr_r[k] <= fr_r[k-1];
        if (fr_r[k-1][NSTEP-k]) m_r[k] <= 31'(prod >> 30);
        else m_r[k] <= m_r[k-1];
      end
    end
  end

  // Scale the Q30 mantissa to Q16 by the integer part.
  always_comb begin
    logic signed [IW-1:0] up, dn;
    up = ip_r[NSTEP] - IP_ONE;
    dn = IP_ONE - ip_r[NSTEP];
    if (ip_r[NSTEP] >= IP_CAP) begin
      z_nxt = {1'b1, {(Z_W-1){1'b0}}};
    end else if (ip_r[NSTEP] >= IP_ONE) begin
      z_nxt = {{(Z_W-31){1'b0}}, m_r[NSTEP]} << up[3:0];
    end else if (ip_r[NSTEP] <= IP_LOW) begin
      z_nxt = '0;
    end else begin
      z_nxt = {{(Z_W-31){1'b0}}, m_r[NSTEP] >> dn[4:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tag_r <= '0;
    end else if (en) begin
      out_tag_r <= tag_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) z_r <= z_nxt;
  end

  assign out_z   = z_r;
  assign out_tag = out_tag_r;

  a_mant: assert property (@(posedge clk) disable iff (!rst_n)
    tag_r[NSTEP].valid |-> m_r[NSTEP][30])
    else $error("exp2 mantissa left its range");

endmodule

// ===== rtl/core/water_vapor_transmittance.sv =====
// Top level: t = exp(-exp(a + b*ln(m*u))) per item, fully pipelined.
// Throughput: one request per cycle; two 18-register exp2 chains and a 17-register
// log2 chain, one multiplier per stage, set the depth. The whole pipeline holds
// while the output register waits on out_tready. Reset (rst_n low, synchronous)
// empties the pipeline and loads the fitted coefficients into the band registers.
`timescale 1ns / 1ps

module water_vapor_transmittance #(
  parameter int unsigned FIRST_BAND = wvt_pkg::FIRST_BAND_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [31:0]                        in_tdata,  // vapor_column, air_mass
  input  logic [wvt_pkg::BAND_W-1:0]         in_tuser,  // band
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata, // transmittance
  output logic                               out_tuser, // band_fitted
  input  logic                               cfg_we,
  input  logic [wvt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wvt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import wvt_pkg::*;

  localparam logic [BAND_W:0] BAND_LO = (BAND_W+1)'(FIRST_BAND);
  localparam logic [BAND_W:0] BAND_HI = (BAND_W+1)'(FIRST_BAND + 3);

  logic en;

  logic signed [OFFSET_W-1:0] offset_r [0:3];
  logic [SLOPE_W-1:0]         slope_r  [0:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r[0] <= OFFSET0_RST;
      offset_r[1] <= OFFSET1_RST;
      offset_r[2] <= OFFSET2_RST;
      offset_r[3] <= OFFSET3_RST;
      slope_r[0]  <= SLOPE0_RST;
      slope_r[1]  <= SLOPE1_RST;
      slope_r[2]  <= SLOPE2_RST;
      slope_r[3]  <= SLOPE3_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OFFSET0: offset_r[0] <= cfg_wdata;
        CFG_OFFSET1: offset_r[1] <= cfg_wdata;
        CFG_OFFSET2: offset_r[2] <= cfg_wdata;
        CFG_OFFSET3: offset_r[3] <= cfg_wdata;
        CFG_SLOPE0:  slope_r[0]  <= cfg_wdata[SLOPE_W-1:0];
        CFG_SLOPE1:  slope_r[1]  <= cfg_wdata[SLOPE_W-1:0];
        CFG_SLOPE2:  slope_r[2]  <= cfg_wdata[SLOPE_W-1:0];
        CFG_SLOPE3:  slope_r[3]  <= cfg_wdata[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 0: capture the request and classify the band.
  wvt_tag_t    tag0_r, tag0_nxt;
  logic [15:0] u0_r, am0_r;
  logic [BAND_W:0] band_ext;

  always_comb begin
    band_ext        = {1'b0, in_tuser};
    tag0_nxt.valid  = in_tvalid;
    tag0_nxt.fitted = (band_ext >= BAND_LO) && (band_ext <= BAND_HI);
    tag0_nxt.zero   = (in_tdata[15:0] == 16'd0) || (in_tdata[31:16] == 16'd0);
    tag0_nxt.idx    = 2'(band_ext - BAND_LO);
  end

  // Stage 1: product of column and air mass.
  wvt_tag_t    tag1_r;
  logic [31:0] p1_r;

  // Stages after the log: ln, fit line, scaling into base 2.
  logic signed [21:0] l2;
  wvt_tag_t           ltag;
  wvt_tag_t           tag2_r, tag3_r, tag4_r;
  logic signed [21:0] lnq2_r;
  logic signed [25:0] y3_r;
  logic signed [27:0] v4_r;
  logic signed [39:0] ln_prod;
  logic signed [40:0] fit_prod;
  logic signed [43:0] scl_prod;

  assign ln_prod  = l2 * LN2_Q16;
  assign fit_prod = $signed({1'b0, slope_r[tag2_r.idx]}) * lnq2_r;
  assign scl_prod = y3_r * LOG2E_Q16;

  // Between the exponentials: w = z*log2(e), then negate.
  logic [Z_W-1:0]     z;
  wvt_tag_t           ztag, tag5_r;
  logic [57:0]        w_prod;
  logic signed [42:0] v5_r;

  assign w_prod = z * 17'd94548;

  logic [Z_W-1:0] t;
  wvt_tag_t       ttag;

  logic        out_tvalid_r;
  logic [15:0] out_tdata_r, out_tdata_nxt;
  logic        out_tuser_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r       <= '0;
      tag1_r       <= '0;
      tag2_r       <= '0;
      tag3_r       <= '0;
      tag4_r       <= '0;
      tag5_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      tag0_r       <= tag0_nxt;
      tag1_r       <= tag0_r;
      tag2_r       <= ltag;
      tag3_r       <= tag2_r;
      tag4_r       <= tag3_r;
      tag5_r       <= ztag;
      out_tvalid_r <= ttag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u0_r        <= in_tdata[15:0];
      am0_r       <= in_tdata[31:16];
      p1_r        <= u0_r * am0_r;
      lnq2_r      <= 22'(ln_prod >>> 16);
      y3_r        <= 26'(offset_r[tag2_r.idx]) + 26'(fit_prod >>> 16);
      v4_r        <= 28'(scl_prod >>> 16);
      v5_r        <= -$signed({1'b0, w_prod[57:16]});
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= ttag.fitted;
    end
  end

  wvt_log2 u_log2 (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_p    (p1_r),
    .in_tag  (tag1_r),
    .out_l2  (l2),
    .out_tag (ltag)
  );

  wvt_exp2 #(.VW(28)) u_exp_inner (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v4_r),
    .in_tag  (tag4_r),
    .out_z   (z),
    .out_tag (ztag)
  );

  wvt_exp2 #(.VW(43)) u_exp_outer (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (v5_r),
    .in_tag  (tag5_r),
    .out_z   (t),
    .out_tag (ttag)
  );

  // Unfitted bands, a zero product and a result above 65535 give 16'hFFFF, the top code (just under 1.0 in Q16).
  always_comb begin
    if (!ttag.fitted || ttag.zero) out_tdata_nxt = 16'hFFFF;
    else if (t > 41'd65535) out_tdata_nxt = 16'hFFFF;
    else out_tdata_nxt = t[15:0];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_unfit_one: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 16'hFFFF))
    else $error("unfitted band did not give 1.0");

  a_bypass_one: assert property (@(posedge clk) disable iff (!rst_n)
    (en && ttag.valid && ttag.zero) |=> (out_tdata == 16'hFFFF))
    else $error("zero product did not give 1.0");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

endmodule
